// ===== design/sample_bundle_framer_assert.svh =====
// Assertion macros for the sample bundle framer.
// Included by the top level; needs i_clk and i_rst_n in scope at the point of use.
`ifndef SAMPLE_BUNDLE_FRAMER_ASSERT_SVH
`define SAMPLE_BUNDLE_FRAMER_ASSERT_SVH

`ifndef SYNTH
// Check that cond holds in the same cycle whenever trig holds.
`define SBF_ASSERT_SAME(label, trig, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error("sbf assertion failed");
// Check that cond holds in the cycle after trig.
`define SBF_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error("sbf assertion failed");
`else
`define SBF_ASSERT_SAME(label, trig, cond)
`define SBF_ASSERT_NEXT(label, trig, cond)
`endif

`endif

// ===== design/sbf_pkg.sv =====
// Shared types and constants for the sample bundle framer.
// No dependencies; compile first.
package sbf_pkg;

    localparam int SBF_MAX_SAMPLES = 8;
    localparam int SBF_IDX_W       = 4;
    localparam int SBF_CFG_W       = 4;
    localparam int SBF_LEN_W       = 6;
    localparam int SBF_PADDR_W     = 3;

    localparam logic [SBF_CFG_W-1:0] SBF_SPB_RESET = 4'd8;
    localparam logic [SBF_LEN_W-1:0] SBF_HDR_BYTES = 6'd2;
    localparam logic                 SBF_REG_SPB   = 1'b0;

    typedef enum logic [1:0] {
        KIND_ADD  = 2'd0,
        KIND_SER  = 2'd1,
        KIND_DONE = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HDR,
        ST_RD,
        ST_BYTE
    } t_state;

    typedef struct packed {
        logic                 we;
        logic                 re;
        logic [SBF_IDX_W-1:0] addr;
        logic [31:0]          wdata;
    } t_mem_req;

    typedef struct packed {
        logic                 ready_flag;
        logic                 busy;
        logic [SBF_IDX_W-1:0] count;
    } t_status;

endpackage

// ===== design/sbf_if.sv =====
// Handshake channels of the sample bundle framer: input items and result items.
// No dependencies.
interface sbf_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] temp_sample;
    logic [15:0] hum_sample;

    modport source (output valid, output kind, output temp_sample, output hum_sample,
                    input ready);
    modport sink   (input valid, input kind, input temp_sample, input hum_sample,
                    output ready);
endinterface

interface sbf_out_if;
    logic       valid;
    logic       ready;
    logic       ready_res;
    logic       became_full;
    logic       byte_valid;
    logic [7:0] payload_byte;
    logic [5:0] payload_length;
    logic       last;

    modport source (output valid, output ready_res, output became_full, output byte_valid,
                    output payload_byte, output payload_length, output last,
                    input ready);
    modport sink   (input valid, input ready_res, input became_full, input byte_valid,
                    input payload_byte, input payload_length, input last,
                    output ready);
endinterface

// ===== design/sample_bundle_framer.sv =====
// Sample bundle framer top level: configuration register, sequencer and sample store.
// Depends on sbf_pkg, sbf_if, sbf_store, sbf_ctrl and sample_bundle_framer_assert.svh.
//
// Usage:
//   i_in carries items of three kinds: add a temperature/humidity sample, serialize the
//   bundle, or report transmission done. o_out carries result items; every item yields
//   exactly one result except a serialize while the bundle is full, which yields the
//   payload one byte per result (sequence number, then each sample, big-endian), with
//   last set on the final byte.
//   The APB port holds samples_per_bundle at byte address 0; pready is always high.
// Sequencing:
//   Add, done and unused kinds yield a status result that is registered and shows the
//   cycle after acceptance. A serialize yields no result on acceptance, then the two
//   header bytes, then per sample one store read (the single memory port) and four
//   bytes through the output register.
// Reset:
//   Synchronous, active low. Clears count, full flag and sequence number and loads the
//   bundle size with 8. The store is not cleared; only written entries are ever read.
// Stalls:
//   When o_out.ready is low the output register holds its result and the sequencer
//   waits; no new item is taken until the pending result can move.
`include "sample_bundle_framer_assert.svh"

module sample_bundle_framer #(
    parameter int MAX_SAMPLES = sbf_pkg::SBF_MAX_SAMPLES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    sbf_in_if.sink                          i_in,
    sbf_out_if.source                       o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sbf_pkg::SBF_PADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import sbf_pkg::*;

    logic [SBF_CFG_W-1:0] r_spb;
    logic [SBF_CFG_W-1:0] n_spb;
    logic                 w_wr;
    t_mem_req             w_mem;
    logic [31:0]          w_rdata;
    t_status              w_status;

    // Write the bundle size on the access phase of an APB write.
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_comb begin
        n_spb = r_spb;
        if (w_wr && (paddr[2] == SBF_REG_SPB)) begin
            n_spb = pwdata[SBF_CFG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spb <= SBF_SPB_RESET;
        end else begin
            r_spb <= n_spb;
        end
    end

    assign prdata = (paddr[2] == SBF_REG_SPB) ? {{(32 - SBF_CFG_W){1'b0}}, r_spb} : 32'd0;

    // Sequencer: owns count, full flag, sequence number and the result register.
    sbf_ctrl #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_spb    (r_spb),
        .i_in     (i_in),
        .o_out    (o_out),
        .o_mem    (w_mem),
        .i_rdata  (w_rdata),
        .o_status (w_status)
    );

    // Store writes happen only on an accepted add and reads only while serializing,
    // so the two never touch the same entry in one cycle.
    sbf_store #(
        .DEPTH (MAX_SAMPLES)
    ) u_store (
        .i_clk   (i_clk),
        .i_req   (w_mem),
        .o_rdata (w_rdata)
    );

    // Count never passes the store depth.
    `SBF_ASSERT_SAME(a_count_bound, 1'b1, w_status.count <= SBF_IDX_W'(MAX_SAMPLES))
    // Serializing only ever runs on a full bundle.
    `SBF_ASSERT_SAME(a_busy_full, w_status.busy, w_status.ready_flag)
    // Transmission done empties the bundle.
    `SBF_ASSERT_NEXT(a_done_clear, i_in.valid && i_in.ready && (i_in.kind == KIND_DONE),
        !w_status.ready_flag && (w_status.count == '0))
    // An add to a full bundle is refused.
    `SBF_ASSERT_NEXT(a_add_refused, i_in.valid && i_in.ready && (i_in.kind == KIND_ADD) && w_status.ready_flag, $stable(w_status.count))

endmodule

// ===== design/sbf_store.sv =====
// Sample store: one synchronous memory of {temperature, humidity} words.
// Depends on sbf_pkg for the request struct.
module sbf_store #(
    parameter int DEPTH = sbf_pkg::SBF_MAX_SAMPLES
) (
    input  logic              i_clk,
    input  sbf_pkg::t_mem_req i_req,
    output logic [31:0]       o_rdata
);
    import sbf_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr[AW-1:0]] <= i_req.wdata;
        end
        // hold read data until the next read
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.addr[AW-1:0]];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/sbf_ctrl.sv =====
// Framer sequencer: bundle state, store access and result register.
// Depends on sbf_pkg and the channel interfaces in sbf_if.
module sbf_ctrl #(
    parameter int MAX_SAMPLES = sbf_pkg::SBF_MAX_SAMPLES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [sbf_pkg::SBF_CFG_W-1:0]    i_spb,
    sbf_in_if.sink                           i_in,
    sbf_out_if.source                        o_out,
    output sbf_pkg::t_mem_req                o_mem,
    input  logic [31:0]                      i_rdata,
    output sbf_pkg::t_status                 o_status
);
    import sbf_pkg::*;

    localparam int CW = $clog2(MAX_SAMPLES + 1);

    t_state                 r_state, n_state;
    logic [CW-1:0]          r_count, n_count;
    logic                   r_ready, n_ready;
    logic [15:0]            r_seq, n_seq;
    logic [CW-1:0]          r_idx, n_idx;
    logic [1:0]             r_sub, n_sub;
    logic [SBF_LEN_W-1:0]   r_len, n_len;

    logic                   r_ov, n_ov;
    logic                   r_o_rdy, n_o_rdy;
    logic                   r_o_full, n_o_full;
    logic                   r_o_bv, n_o_bv;
    logic [7:0]             r_o_byte, n_o_byte;
    logic [SBF_LEN_W-1:0]   r_o_len, n_o_len;
    logic                   r_o_last, n_o_last;

    logic [CW-1:0]          w_tgt;
    logic [CW-1:0]          w_cnt_add;
    logic                   w_out_free;
    logic                   w_acc;
    logic                   w_last;

    // clamp the bundle size into 1..MAX_SAMPLES
    always_comb begin
        if (i_spb == '0) begin
            w_tgt = CW'(1);
        end else if (int'(i_spb) > MAX_SAMPLES) begin
            w_tgt = CW'(MAX_SAMPLES);
        end else begin
            w_tgt = CW'(i_spb);
        end
    end

    assign w_cnt_add  = (r_count < w_tgt) ? r_count + CW'(1) : r_count;
    assign w_out_free = !r_ov || o_out.ready;
    assign i_in.ready = (r_state == ST_IDLE) && w_out_free;
    assign w_acc      = i_in.valid && i_in.ready;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ready  = r_ready;
        n_seq    = r_seq;
        n_idx    = r_idx;
        n_sub    = r_sub;
        n_len    = r_len;
        n_ov     = r_ov && !o_out.ready;
        n_o_rdy  = r_o_rdy;
        n_o_full = r_o_full;
        n_o_bv   = r_o_bv;
        n_o_byte = r_o_byte;
        n_o_len  = r_o_len;
        n_o_last = r_o_last;
        o_mem    = '0;
        w_last   = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    // status result by default
                    n_ov     = 1'b1;
                    n_o_full = 1'b0;
                    n_o_bv   = 1'b0;
                    n_o_byte = '0;
                    n_o_len  = '0;
                    n_o_last = 1'b1;
                    n_o_rdy  = r_ready;
                    case (t_kind'(i_in.kind))
                        KIND_ADD: begin
                            if (!r_ready) begin
                                if (r_count < w_tgt) begin
                                    o_mem.we    = 1'b1;
                                    o_mem.addr  = SBF_IDX_W'(r_count);
                                    o_mem.wdata = {i_in.temp_sample, i_in.hum_sample};
                                end
                                n_count = w_cnt_add;
                                if (w_cnt_add >= w_tgt) begin
                                    n_ready  = 1'b1;
                                    n_o_rdy  = 1'b1;
                                    n_o_full = 1'b1;
                                end
                            end
                        end
                        KIND_SER: begin
                            if (r_ready) begin
                                // no result now; header bytes follow
                                n_ov    = 1'b0;
                                n_len   = SBF_HDR_BYTES + (SBF_LEN_W'(r_count) << 2);
                                n_sub   = '0;
                                n_state = ST_HDR;
                            end
                        end
                        KIND_DONE: begin
                            n_seq   = r_seq + 16'd1;
                            n_count = '0;
                            n_ready = 1'b0;
                            n_o_rdy = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_HDR: begin
                if (w_out_free) begin
                    w_last   = r_sub[0] && (r_count == '0);
                    n_ov     = 1'b1;
                    n_o_rdy  = r_ready;
                    n_o_full = 1'b0;
                    n_o_bv   = 1'b1;
                    n_o_byte = r_sub[0] ? r_seq[7:0] : r_seq[15:8];
                    n_o_len  = r_len;
                    n_o_last = w_last;
                    if (r_sub[0]) begin
                        n_sub   = '0;
                        n_idx   = '0;
                        n_state = w_last ? ST_IDLE : ST_RD;
                    end else begin
                        n_sub = 2'd1;
                    end
                end
            end
            ST_RD: begin
                o_mem.re   = 1'b1;
                o_mem.addr = SBF_IDX_W'(r_idx);
                n_sub      = '0;
                n_state    = ST_BYTE;
            end
            ST_BYTE: begin
                if (w_out_free) begin
                    w_last   = (r_sub == 2'd3) && (r_idx + CW'(1) == r_count);
                    n_ov     = 1'b1;
                    n_o_rdy  = r_ready;
                    n_o_full = 1'b0;
                    n_o_bv   = 1'b1;
                    n_o_len  = r_len;
                    n_o_last = w_last;
                    case (r_sub)
                        2'd0:    n_o_byte = i_rdata[31:24];
                        2'd1:    n_o_byte = i_rdata[23:16];
                        2'd2:    n_o_byte = i_rdata[15:8];
                        default: n_o_byte = i_rdata[7:0];
                    endcase
                    n_sub = r_sub + 2'd1;
                    if (r_sub == 2'd3) begin
                        n_idx   = r_idx + CW'(1);
                        n_state = w_last ? ST_IDLE : ST_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_ready <= 1'b0;
            r_seq   <= '0;
            r_idx   <= '0;
            r_sub   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ready <= n_ready;
            r_seq   <= n_seq;
            r_idx   <= n_idx;
            r_sub   <= n_sub;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len    <= n_len;
        r_o_rdy  <= n_o_rdy;
        r_o_full <= n_o_full;
        r_o_bv   <= n_o_bv;
        r_o_byte <= n_o_byte;
        r_o_len  <= n_o_len;
        r_o_last <= n_o_last;
    end

    assign o_out.valid          = r_ov;
    assign o_out.ready_res      = r_o_rdy;
    assign o_out.became_full    = r_o_full;
    assign o_out.byte_valid     = r_o_bv;
    assign o_out.payload_byte   = r_o_byte;
    assign o_out.payload_length = r_o_len;
    assign o_out.last           = r_o_last;

    assign o_status.ready_flag = r_ready;
    assign o_status.busy       = (r_state != ST_IDLE);
    assign o_status.count      = SBF_IDX_W'(r_count);

endmodule

// ===== verif/tb_sample_bundle_framer.sv =====
// Self-checking testbench for sample_bundle_framer: directed and random items, random idling.
// Depends on sbf_pkg, sbf_if (sbf_in_if, sbf_out_if) and the sample_bundle_framer RTL.
module tb_sample_bundle_framer;
    import sbf_pkg::*;

    // Kind code that the block ignores apart from one status result.
    localparam logic [1:0] KIND_RSVD = 2'd3;

    // Register 0 (bundle size) sits at byte address 0.
    localparam logic [SBF_PADDR_W-1:0] ADDR_BUNDLE_SIZE = {SBF_REG_SPB, 2'b00};

    localparam int RANDOM_ITEMS  = 330;
    localparam int RANDOM_PHASES = 6;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int REPORT_LIMIT  = 10;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SEQ_STEPS     = 5;

    // One result item as the block should present it.
    typedef struct packed {
        logic       ready_res;
        logic       became_full;
        logic       byte_valid;
        logic [7:0] payload_byte;
        logic [5:0] payload_length;
        logic       last;
    } t_frame_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [SBF_PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sbf_in_if  in_if ();
    sbf_out_if out_if ();

    sample_bundle_framer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the framer state, advanced on every accepted item.
    logic [15:0] shadow_temp [SBF_MAX_SAMPLES];
    logic [15:0] shadow_hum  [SBF_MAX_SAMPLES];
    int unsigned shadow_count;
    logic        shadow_full;
    logic [15:0] shadow_seq;
    logic [3:0]  shadow_bundle_size;

    // Results owed by the block, oldest first.
    t_frame_result pending_results [$];

    int  fail_count;
    int  items_sent;
    int  cycle_count;
    int  hold_request;
    bit  gaps_on;
    bit  stalls_on;

    // 2-unit clock period.
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Queue one result; ready_res always reflects the flag after the item.
    function automatic void owe_result(input logic full, input logic valid,
                                       input logic [7:0] data, input logic [5:0] len,
                                       input logic last);
        t_frame_result r;
        r.ready_res      = shadow_full;
        r.became_full    = full;
        r.byte_valid     = valid;
        r.payload_byte   = data;
        r.payload_length = len;
        r.last           = last;
        pending_results.push_back(r);
    endfunction

    // Advance the shadow state by one accepted item and queue every result it causes.
    function automatic void predict_framer_results(input logic [1:0] kind,
                                                   input logic [15:0] temp,
                                                   input logic [15:0] hum);
        int unsigned target;
        logic [5:0]  len;
        logic        full;
        // Zero counts as one, anything past the store depth saturates.
        if (shadow_bundle_size == 4'd0)
            target = 1;
        else if (shadow_bundle_size > SBF_MAX_SAMPLES)
            target = SBF_MAX_SAMPLES;
        else
            target = shadow_bundle_size;
        full = 1'b0;
        case (kind)
            KIND_ADD: begin
                // A full bundle refuses samples; a lowered threshold fills without storing.
                if (!shadow_full) begin
                    if (shadow_count < target && shadow_count < SBF_MAX_SAMPLES) begin
                        shadow_temp[shadow_count] = temp;
                        shadow_hum[shadow_count]  = hum;
                        shadow_count++;
                    end
                    if (shadow_count >= target) begin
                        shadow_full = 1'b1;
                        full        = 1'b1;
                    end
                end
                owe_result(full, 1'b0, 8'h00, 6'd0, 1'b1);
            end
            KIND_SER: begin
                if (!shadow_full) begin
                    owe_result(1'b0, 1'b0, 8'h00, 6'd0, 1'b1);
                end else begin
                    len = 6'(2 + 4 * shadow_count);
                    owe_result(1'b0, 1'b1, shadow_seq[15:8], len, 1'b0);
                    owe_result(1'b0, 1'b1, shadow_seq[7:0], len, shadow_count == 0);
                    for (int i = 0; i < shadow_count; i++) begin
                        owe_result(1'b0, 1'b1, shadow_temp[i][15:8], len, 1'b0);
                        owe_result(1'b0, 1'b1, shadow_temp[i][7:0], len, 1'b0);
                        owe_result(1'b0, 1'b1, shadow_hum[i][15:8], len, 1'b0);
                        owe_result(1'b0, 1'b1, shadow_hum[i][7:0], len,
                                   i + 1 == shadow_count);
                    end
                end
            end
            KIND_DONE: begin
                shadow_seq   = shadow_seq + 16'd1;
                shadow_count = 0;
                shadow_full  = 1'b0;
                owe_result(1'b0, 1'b0, 8'h00, 6'd0, 1'b1);
            end
            default: begin
                owe_result(1'b0, 1'b0, 8'h00, 6'd0, 1'b1);
            end
        endcase
    endfunction

    // Sample values lean toward the extremes now and then.
    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Offer one item and hold it until accepted; valid stays high for the next call.
    task automatic send_item(input logic [1:0] kind, input logic [15:0] temp,
                             input logic [15:0] hum);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.kind        <= kind;
        in_if.temp_sample <= temp;
        in_if.hum_sample  <= hum;
        do @(posedge i_clk); while (!in_if.ready);
        predict_framer_results(kind, temp, hum);
        items_sent++;
    endtask

    // Drop valid, wait for every owed result, then let the sequencer settle.
    task automatic drain_results();
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write of the bundle size: setup cycle, then access until pready.
    task automatic write_bundle_size(input logic [3:0] size);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BUNDLE_SIZE;
        pwdata  <= 32'(size);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shadow_bundle_size = size;
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial begin : result_sink
        int n;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                n = hold_request;
                hold_request = 0;
                out_if.ready <= 1'b0;
                while (n > 1) begin
                    @(posedge i_clk);
                    n--;
                end
            end else if (stalls_on && $urandom_range(0, 7) == 0) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 17) - 1) @(posedge i_clk);
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // Compare every accepted result with the oldest owed one.
    always @(posedge i_clk) begin : check_results
        t_frame_result got;
        t_frame_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.ready_res      = out_if.ready_res;
            got.became_full    = out_if.became_full;
            got.byte_valid     = out_if.byte_valid;
            got.payload_byte   = out_if.payload_byte;
            got.payload_length = out_if.payload_length;
            got.last           = out_if.last;
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("unexpected: rdy=%0b full=%0b bv=%0b byte=%02h len=%0d last=%0b",
                             got.ready_res, got.became_full, got.byte_valid,
                             got.payload_byte, got.payload_length, got.last);
            end else begin
                want = pending_results.pop_front();
                if (got.ready_res !== want.ready_res || got.became_full !== want.became_full
                        || got.byte_valid !== want.byte_valid
                        || got.payload_byte !== want.payload_byte
                        || got.payload_length !== want.payload_length
                        || got.last !== want.last) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("mismatch: want rdy=%0b full=%0b bv=%0b byte=%02h len=%0d last=%0b",
                                 want.ready_res, want.became_full, want.byte_valid,
                                 want.payload_byte, want.payload_length, want.last);
                        $display("          got  rdy=%0b full=%0b bv=%0b byte=%02h len=%0d last=%0b",
                                 got.ready_res, got.became_full, got.byte_valid,
                                 got.payload_byte, got.payload_length, got.last);
                    end
                end
            end
        end
    end

    // Default size after reset: fill all eight entries with bit-extreme values,
    // try one sample too many, then serialize the full 34-byte payload and close it.
    task automatic test_full_bundle();
        logic [15:0] temps [SBF_MAX_SAMPLES];
        logic [15:0] hums  [SBF_MAX_SAMPLES];
        temps = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0001,
                  16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00};
        hums  = '{16'hFFFF, 16'h0000, 16'h0001, 16'h8000,
                  16'hAAAA, 16'h5555, 16'hFF00, 16'h00FF};
        for (int i = 0; i < SBF_MAX_SAMPLES; i++)
            send_item(KIND_ADD, temps[i], hums[i]);
        send_item(KIND_ADD, 16'h1234, 16'h5678);
        send_item(KIND_SER, 16'h0000, 16'h0000);
        send_item(KIND_DONE, 16'h0000, 16'h0000);
    endtask

    // Serialize and done while the bundle is not full, and the unused kind.
    task automatic test_status_kinds();
        send_item(KIND_SER, 16'hFFFF, 16'hFFFF);
        send_item(KIND_DONE, 16'hFFFF, 16'h0000);
        send_item(KIND_RSVD, 16'hA5A5, 16'h5A5A);
    endtask

    // A size of zero behaves as one sample per bundle.
    task automatic test_size_zero();
        drain_results();
        write_bundle_size(4'd0);
        send_item(KIND_ADD, 16'hBEEF, 16'hCAFE);
        send_item(KIND_SER, 16'h0000, 16'h0000);
        send_item(KIND_DONE, 16'h0000, 16'h0000);
    endtask

    // Lower the size below the stored count: the next add stores nothing but fills.
    task automatic test_threshold_drop();
        drain_results();
        write_bundle_size(4'd8);
        for (int i = 0; i < 4; i++)
            send_item(KIND_ADD, pick_sample(), pick_sample());
        drain_results();
        write_bundle_size(4'd2);
        send_item(KIND_ADD, 16'h7777, 16'h8888);
        send_item(KIND_SER, 16'h0000, 16'h0000);
        send_item(KIND_DONE, 16'h0000, 16'h0000);
    endtask

    // Hold the receiver off for a long stretch while items keep coming,
    // so the output register fills and the input stalls.
    task automatic test_output_backpressure();
        drain_results();
        write_bundle_size(4'd8);
        hold_request = HOLD_CYCLES;
        while (!shadow_full)
            send_item(KIND_ADD, pick_sample(), pick_sample());
        send_item(KIND_SER, 16'h0000, 16'h0000);
        send_item(KIND_DONE, 16'h0000, 16'h0000);
        for (int i = 0; i < 6; i++)
            send_item(KIND_ADD, pick_sample(), pick_sample());
        drain_results();
    endtask

    // Step the sequence number through back-to-back done items, then
    // serialize single-sample bundles at two successive values.
    task automatic test_sequence_steps();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        drain_results();
        write_bundle_size(4'd1);
        for (int i = 0; i < SEQ_STEPS; i++)
            send_item(KIND_DONE, 16'h0000, 16'h0000);
        for (int i = 0; i < 2; i++) begin
            send_item(KIND_ADD, pick_sample(), pick_sample());
            send_item(KIND_SER, 16'h0000, 16'h0000);
            send_item(KIND_DONE, 16'h0000, 16'h0000);
        end
        drain_results();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    // Random traffic in phases of different sizes. Mostly complete bundles
    // (fill, sometimes one or two refused adds, one or two serializes, done) with random samples;
    // the rest is noise of random kinds. The last phase runs without idling.
    task automatic test_random_bundles();
        logic [3:0] sizes [RANDOM_PHASES];
        int stop_at;
        sizes = '{4'd1, 4'd8, 4'd15, 4'd0, 4'($urandom_range(2, 7)),
                  4'($urandom_range(0, 15))};
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain_results();
            if (p == RANDOM_PHASES - 1) begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end
            write_bundle_size(sizes[p]);
            stop_at = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
            while (items_sent < stop_at) begin
                if ($urandom_range(0, 9) < 8) begin
                    while (!shadow_full)
                        send_item(KIND_ADD, pick_sample(), pick_sample());
                    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0)
                        send_item(KIND_ADD, pick_sample(), pick_sample());
                    repeat ($urandom_range(1, 2))
                        send_item(KIND_SER, pick_sample(), pick_sample());
                    if ($urandom_range(0, 5) == 0)
                        send_item(KIND_RSVD, pick_sample(), pick_sample());
                    send_item(KIND_DONE, pick_sample(), pick_sample());
                end else begin
                    repeat ($urandom_range(1, 4))
                        send_item(2'($urandom_range(0, 3)), pick_sample(), pick_sample());
                end
            end
        end
    endtask

    initial begin
        shadow_count       = 0;
        shadow_full        = 1'b0;
        shadow_seq         = 16'h0000;
        shadow_bundle_size = SBF_SPB_RESET;
        fail_count         = 0;
        items_sent         = 0;
        cycle_count        = 0;
        hold_request       = 0;
        gaps_on            = 1'b1;
        stalls_on          = 1'b1;
        // Drive every input to a known value before the first edge.
        i_rst_n           <= 1'b0;
        in_if.valid       <= 1'b0;
        in_if.kind        <= KIND_ADD;
        in_if.temp_sample <= 16'h0000;
        in_if.hum_sample  <= 16'h0000;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= 32'h0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_full_bundle();
        test_status_kinds();
        test_size_zero();
        test_threshold_drop();
        test_output_backpressure();
        test_sequence_steps();
        test_random_bundles();

        drain_results();
        if (fail_count == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/sbf_pkg.sv
design/sbf_if.sv
design/sbf_store.sv
design/sbf_ctrl.sv
design/sample_bundle_framer.sv
verif/tb_sample_bundle_framer.sv
